@@ rtl/bfp_pkg.sv @@
// shared constants and item type for the bit field packer
package bfp_pkg;

  localparam int MAX_FIELD_BITS = 64;
  localparam int FIELD_W        = 64;
  localparam int NBITS_W        = 7;
  localparam int BYTE_W         = 8;
  localparam int CNT_W          = 3;
  localparam int STEP_W         = 4;
  localparam int IN_TDATA_W     = 72;

  // one normalized item: stream bit i sits in stream[i]
  typedef struct packed {
    logic [FIELD_W-1:0] stream;
    logic [NBITS_W-1:0] nbits;
    logic               flush;
    logic               msb_first;
  } bfp_item_t;

endpackage

@@ rtl/bfp_front.sv @@
// front end: mode register, field saturation and reordering into stream order
module bfp_front import bfp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic                  cfg_data,
  input  logic                  s_tvalid,
  input  logic [IN_TDATA_W-1:0] s_tdata,
  input  logic                  s_tlast,
  input  logic                  q_full,
  output logic                  s_tready,
  output logic                  push,
  output bfp_item_t             push_item
);

  logic               msb_first;
  logic [FIELD_W-1:0] field_value;
  logic [NBITS_W-1:0] field_bits;
  logic [NBITS_W-1:0] nbits_sat;
  logic [NBITS_W-1:0] shift;
  logic [FIELD_W-1:0] aligned;
  logic [FIELD_W-1:0] reversed;

  always_ff @(posedge clk) begin
    if (rst) begin
      msb_first <= 1'b0;
    end else if (cfg_valid) begin
      msb_first <= cfg_data;
    end
  end

  assign field_value = s_tdata[FIELD_W-1:0];
  assign field_bits  = s_tdata[FIELD_W+NBITS_W-1:FIELD_W];

  always_comb begin
    nbits_sat = (field_bits > NBITS_W'(MAX_FIELD_BITS)) ? NBITS_W'(MAX_FIELD_BITS) : field_bits;
    // msb first: left-align the field, then reverse so its top bit lands in bit 0
    shift   = NBITS_W'(FIELD_W) - nbits_sat;
    aligned = field_value << shift;
    for (int i = 0; i < FIELD_W; i++) begin
      reversed[i] = aligned[FIELD_W-1-i];
    end
    push_item.stream    = msb_first ? reversed : field_value;
    push_item.nbits     = nbits_sat;
    push_item.flush     = s_tlast;
    push_item.msb_first = msb_first;
  end

  assign s_tready = ~q_full;
  assign push     = s_tvalid & ~q_full;

endmodule

@@ rtl/bfp_queue.sv @@
// two-entry item queue between front and back
module bfp_queue import bfp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  bfp_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      pop_valid,
  output bfp_item_t pop_item
);

  bfp_item_t  entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  assign full      = count[1];
  assign pop_valid = (count != 2'd0);
  assign pop_item  = entries[rd_ptr];

endmodule

@@ rtl/bfp_back.sv @@
// back end: byte assembler, one byte boundary per step, with output register
module bfp_back import bfp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  bfp_item_t         item,
  output logic              item_pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [BYTE_W-1:0] m_tdata,
  output logic              m_tlast
);

  // current item
  logic               cur_valid;
  logic [FIELD_W-1:0] stream;
  logic [NBITS_W-1:0] rem;
  logic               flush;
  logic               msb_first;
  // partial byte state
  logic [BYTE_W-1:0]  pending;
  logic [CNT_W-1:0]   pc;
  // output register
  logic               out_valid;
  logic [BYTE_W-1:0]  out_byte;
  logic               out_last;

  logic [STEP_W-1:0]  room;
  logic [STEP_W-1:0]  k;
  logic [BYTE_W-1:0]  low_mask;
  logic [BYTE_W-1:0]  slot_mask;
  logic [BYTE_W-1:0]  slot_bits;
  logic [BYTE_W-1:0]  pos_mask;
  logic [BYTE_W-1:0]  pos_bits;
  logic [BYTE_W-1:0]  byte_next;
  logic [STEP_W-1:0]  pc_sum;
  logic [NBITS_W-1:0] rem_next;
  logic               full_byte;
  logic               done;
  logic               flush_emit;
  logic               emit;
  logic               last;
  logic               advance;

  always_comb begin
    room      = STEP_W'(BYTE_W) - {1'b0, pc};
    k         = (rem < NBITS_W'(room)) ? rem[STEP_W-1:0] : room;
    low_mask  = BYTE_W'({BYTE_W{1'b1}} >> (STEP_W'(BYTE_W) - k));
    slot_mask = low_mask << pc;
    slot_bits = (stream[BYTE_W-1:0] << pc) & slot_mask;
    // msb first mode fills bit 7 downwards
    for (int i = 0; i < BYTE_W; i++) begin
      pos_mask[i] = msb_first ? slot_mask[BYTE_W-1-i] : slot_mask[i];
      pos_bits[i] = msb_first ? slot_bits[BYTE_W-1-i] : slot_bits[i];
    end
    byte_next  = (pending & ~pos_mask) | pos_bits;
    pc_sum     = {1'b0, pc} + k;
    full_byte  = pc_sum[CNT_W];
    rem_next   = rem - NBITS_W'(k);
    done       = (rem_next == '0);
    flush_emit = done && flush && !full_byte && (pc_sum != '0);
    emit       = full_byte || flush_emit;
    // more bytes follow only if a whole byte or a flushed tail is left
    last       = !((rem_next >= NBITS_W'(BYTE_W)) || (flush && (rem_next != '0)));
    advance    = cur_valid && (!emit || !out_valid || m_tready);
    item_pop   = item_valid && (!cur_valid || (advance && done));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      pending   <= '0;
      pc        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        if (emit) begin
          pending <= '0;
          pc      <= '0;
        end else begin
          pending <= byte_next;
          pc      <= pc_sum[CNT_W-1:0];
        end
      end
      if (item_pop) begin
        cur_valid <= 1'b1;
      end else if (advance && done) begin
        cur_valid <= 1'b0;
      end
      if (advance && emit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop) begin
      stream    <= item.stream;
      rem       <= item.nbits;
      flush     <= item.flush;
      msb_first <= item.msb_first;
    end else if (advance) begin
      stream <= stream >> k;
      rem    <= rem_next;
    end
    if (advance && emit) begin
      out_byte <= byte_next;
      out_last <= last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_byte;
  assign m_tlast  = out_last;

endmodule

@@ rtl/bit_field_packer.sv @@
// top level of the bit field packer: front end, item queue, byte assembler
// path: a taken word passes the queue entry, the assembler's current item, then the output register
// throughput: the assembler takes one chunk per cycle, each chunk ending at a byte
//   boundary or at the end of the field, behind the single-byte output port; it
//   stalls while a full output register is held by m_tready low
// reset: rst clears the queue, the pending partial byte and msb_first (lsb first)
module bit_field_packer import bfp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // mode register write, always taken
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_data,    // msb_first
  // field input
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_TDATA_W-1:0] s_tdata,     // field_value[63:0], field_bits[70:64], zero pad
  input  logic                  s_tlast,     // flush: pad and send the partial byte
  // byte output
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [BYTE_W-1:0]     m_tdata,     // out_byte[7:0]
  output logic                  m_tlast      // last_of_run
);

  logic      q_full;
  logic      push;
  bfp_item_t push_item;
  logic      pop;
  logic      pop_valid;
  bfp_item_t pop_item;

  // config must only be written while idle (the block does not enforce it), so it never needs to stall
  assign cfg_ready = 1'b1;

  // front saturates the width and turns the field into stream bit order
  bfp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .q_full    (q_full),
    .s_tready  (s_tready),
    .push      (push),
    .push_item (push_item)
  );

  // short queue so input and output stall independently
  bfp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_item  (pop_item)
  );

  // back end merges bits into the partial byte and sends finished bytes
  bfp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (pop_valid),
    .item       (pop_item),
    .item_pop   (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

@@ bench/tb_top.sv @@
// self-checking bench for bit_field_packer: random field stream, predicted byte stream
module tb_top import bfp_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // stall and timing knobs
  localparam int LONG_HOLD      = 300;   // one long output stall, in cycles
  localparam int QUIET_CYCLES   = 40;    // settle time before a mode write or the end
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
  localparam int RANDOM_PHASES  = 5;
  localparam int PHASE_FIELDS   = 30;

  // one field word as the sender sees it
  typedef struct {
    logic [FIELD_W-1:0] value;
    logic [NBITS_W-1:0] nbits;
    logic               flush;
  } field_word_t;

  // one byte word as the receiver sees it
  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              last;
  } byte_word_t;

  // receiver ready styles
  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_MOSTLY, RX_PATTERN} rx_style_t;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic                  cfg_data  = 1'b0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_TDATA_W-1:0] s_tdata   = '0;   // field_value[63:0], field_bits[70:64], zero pad
  logic                  s_tlast   = 1'b0; // flush
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [BYTE_W-1:0]     m_tdata;          // out_byte[7:0]
  logic                  m_tlast;          // last_of_run

  bit_field_packer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // pending field words and the byte stream they must produce
  field_word_t fields_to_send[$];
  byte_word_t  bytes_due[$];

  // predictor state: partial byte, its bit count and the current bit order
  logic [BYTE_W-1:0] pack_byte = '0;
  int                pack_count = 0;
  bit                mode_msb   = 1'b0;

  // bookkeeping, updated on the rising edge, but for fields_queued, counted as fields are added
  int fields_queued  = 0;
  int fields_taken   = 0;
  int flush_fields   = 0;
  int bytes_checked  = 0;
  int mode_writes    = 0;
  int mismatches     = 0;
  int idle_cycles    = 0;
  bit in_taken       = 1'b0;

  // long stall requests to the receiver
  int holds_asked = 0;
  int holds_done  = 0;

  // append one field to the partial byte and queue every byte it completes;
  // bits land at the slot the current order gives, so a mode change
  // mid-byte keeps the bits already placed
  task automatic pack_field(input field_word_t w);
    int         n;
    int         src;
    int         pos;
    byte_word_t run[$];
    byte_word_t b;
    n = (int'(w.nbits) > MAX_FIELD_BITS) ? MAX_FIELD_BITS : int'(w.nbits);
    for (int i = 0; i < n; i++) begin
      src = mode_msb ? (n - 1 - i) : i;
      pos = mode_msb ? (7 - pack_count) : pack_count;
      pack_byte[pos] = w.value[src];
      pack_count++;
      if (pack_count == 8) begin
        b.data = pack_byte;
        b.last = 1'b0;
        run.push_back(b);
        pack_byte  = '0;
        pack_count = 0;
      end
    end
    // flush pads with zeros, and only if something is pending
    if (w.flush && pack_count != 0) begin
      b.data = pack_byte;
      b.last = 1'b0;
      run.push_back(b);
      pack_byte  = '0;
      pack_count = 0;
    end
    foreach (run[k]) begin
      b      = run[k];
      b.last = (k == run.size() - 1);
      bytes_due.push_back(b);
    end
  endtask

  // sender: bursts of random length with random gaps, changes on the falling edge
  int burst_left = 4;
  int gap_left   = 0;

  always @(negedge clk) begin
    field_word_t w;
    logic        next_valid;
    int          r;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tlast  <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      next_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (fields_to_send.size() > 0) begin
        w = fields_to_send.pop_front();
        next_valid = 1'b1;
        s_tdata <= {1'b0, w.nbits, w.value};
        s_tlast <= w.flush;
        if (burst_left <= 1) begin
          // end of burst: pick the next burst and the gap before it
          burst_left = $urandom_range(1, 12);
          r = $urandom_range(0, 9);
          if (r < 4)
            gap_left = 0;
          else if (r < 8)
            gap_left = $urandom_range(1, 3);
          else
            gap_left = $urandom_range(4, 20);
        end else begin
          burst_left--;
        end
      end
      s_tvalid <= next_valid;
    end
  end

  // receiver: ready follows a randomly chosen style, redrawn when its run ends,
  // and a requested long stall overrides it
  rx_style_t   rx_style   = RX_FREE;
  int          style_left = 0;
  int          hold_left  = 0;
  logic [15:0] stall_pat  = '1;
  int          pat_idx    = 0;

  always @(negedge clk) begin
    logic ready;
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (holds_asked != holds_done) begin
      holds_done++;
      hold_left = LONG_HOLD - 1;
      m_tready <= 1'b0;
    end else begin
      if (style_left == 0) begin
        rx_style   = rx_style_t'($urandom_range(0, 3));
        style_left = $urandom_range(16, 80);
        stall_pat  = 16'($urandom);
      end
      style_left--;
      case (rx_style)
        RX_FREE:   ready = 1'b1;
        RX_COIN:   ready = 1'($urandom_range(0, 1));
        RX_MOSTLY: ready = ($urandom_range(0, 7) != 0);
        default: begin
          ready   = stall_pat[pat_idx % 16];
          pat_idx = pat_idx + 1;
        end
      endcase
      m_tready <= ready;
    end
  end

  // rising edge: mode writes, field words into the predictor, byte words
  // against the oldest prediction, and the watchdog
  always @(posedge clk) begin
    field_word_t got;
    byte_word_t  want;
    in_taken <= !rst && s_tvalid && s_tready;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        mode_msb = cfg_data;
        mode_writes++;
      end
      if (s_tvalid && s_tready) begin
        got.value = s_tdata[FIELD_W-1:0];
        got.nbits = s_tdata[FIELD_W +: NBITS_W];
        got.flush = s_tlast;
        pack_field(got);
        fields_taken++;
        if (got.flush)
          flush_fields++;
      end
      if (m_tvalid && m_tready) begin
        bytes_checked++;
        if (bytes_due.size() == 0) begin
          $display("%0t: byte %02h last %0b with no byte expected", $time, m_tdata, m_tlast);
          mismatches++;
        end else begin
          want = bytes_due.pop_front();
          if (m_tdata !== want.data) begin
            $display("%0t: out_byte expected %02h actual %02h", $time, want.data, m_tdata);
            mismatches++;
          end
          if (m_tlast !== want.last) begin
            $display("%0t: last_of_run expected %0b actual %0b", $time, want.last, m_tlast);
            mismatches++;
          end
        end
      end
      if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no word moved for %0d cycles, %0d bytes still due",
                 $time, idle_cycles, bytes_due.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic add_field(input logic [FIELD_W-1:0] v, input int n, input bit fl);
    field_word_t w;
    w.value = v;
    w.nbits = n[NBITS_W-1:0];
    w.flush = fl;
    fields_to_send.push_back(w);
    fields_queued++;
  endtask

  // every field taken and every byte seen, then time for zero-byte fields
  // still in the queue to drain
  task automatic wait_quiet();
    do
      @(negedge clk);
    while (fields_taken != fields_queued || bytes_due.size() != 0);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic write_mode(input bit m);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do
      @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [FIELD_W-1:0] v;
    int                 n;
    int                 r;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // lsb first out of reset
    add_field('0, 0, 1'b0);                      // empty field, nothing comes out
    add_field('0, 0, 1'b1);                      // flush with nothing pending
    add_field(64'h5, 3, 1'b0);
    add_field('1, 64, 1'b0);                     // all ones across byte boundaries
    add_field('0, 64, 1'b1);                     // eight bytes plus the padded one
    add_field({$urandom, $urandom}, 127, 1'b0);  // oversized width saturates
    add_field({$urandom, $urandom}, 65, 1'b1);
    add_field(64'h1, 1, 1'b1);
    add_field(64'hA5A5_A5A5_A5A5_A5A5, 8, 1'b0);
    add_field(64'h2B, 5, 1'b0);                  // leave five bits pending
    wait_quiet();

    // msb first, starting mid-byte
    write_mode(1'b1);
    add_field(64'h3, 3, 1'b0);                   // completes the byte begun in lsb order
    add_field('0, 0, 1'b1);
    add_field(64'h1, 1, 1'b0);
    add_field('0, 0, 1'b1);                      // empty field flushes one pending bit
    add_field(64'h8000_0000_0000_0001, 64, 1'b1);
    add_field('1, 127, 1'b1);
    add_field({$urandom, $urandom}, 7, 1'b0);
    add_field({$urandom, $urandom}, 63, 1'b1);
    add_field(64'h6, 3, 1'b0);                   // three bits left for the next mode
    wait_quiet();

    // random phases, mode rewritten each time, one with a long output stall
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_mode((p < 4) ? p[0] : 1'($urandom_range(0, 1)));
      if (p == 2) begin
        @(posedge clk);
        holds_asked++;
      end
      for (int k = 0; k < PHASE_FIELDS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 12)
          n = 0;
        else if (r < 22)
          n = 64;
        else if (r < 30)
          n = $urandom_range(65, 127);
        else if (r < 55)
          n = $urandom_range(1, 8);
        else
          n = $urandom_range(9, 63);
        v = {$urandom, $urandom};
        if ($urandom_range(0, 9) == 0)
          v = $urandom_range(0, 1) ? '1 : '0;
        add_field(v, n, $urandom_range(0, 3) == 0);
      end
      wait_quiet();
    end

    if (bytes_due.size() != 0) begin
      $display("%0t: %0d bytes expected but never sent", $time, bytes_due.size());
      mismatches++;
    end
    $display("fed %0d fields (%0d with flush) under both bit orders, %0d mode writes",
             fields_taken, flush_fields, mode_writes);
    $display("checked %0d bytes through bursty input, output stalls and one long hold",
             bytes_checked);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

@@ files.f @@
rtl/bfp_pkg.sv
rtl/bfp_front.sv
rtl/bfp_queue.sv
rtl/bfp_back.sv
rtl/bit_field_packer.sv
bench/tb_top.sv
